>>> hdl/tcgp_pkg.sv
// Shared constants and types for the texel colour-key / greyscale packer.
package tcgp_pkg;

   // Pixel and result widths
   localparam int PIX_W      = 8;
   localparam int TEXEL_W    = 32;
   localparam int INDEX_W    = 24;

   // Row geometry
   localparam int MAX_WIDTH  = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int WIDTH_W    = 13;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int KEY_W      = 3 * PIX_W;

   // Luminance weights in hundredths, and 1/100 as a fixed-point reciprocal
   localparam int SUM_W      = 15;
   localparam int LUM_WR     = 30;
   localparam int LUM_WG     = 59;
   localparam int LUM_WB     = 11;
   localparam int RECIP_W    = 13;
   localparam int RECIP_SH   = 19;
   localparam int PROD_W     = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] LUM_RECIP = RECIP_W'(5243);

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_ENABLE  = 3'd0,
      CSR_KEY_COLOR   = 3'd1,
      CSR_MONO_ENABLE = 3'd2,
      CSR_OUT_FORMAT  = 3'd3,
      CSR_IMAGE_WIDTH = 3'd4,
      CSR_ROW_STRIDE  = 3'd5
   } csr_index_type;

   // Texel packing formats
   typedef enum logic {
      FMT_RGBA4444 = 1'b0,
      FMT_RGBA8888 = 1'b1
   } out_format_type;

   // Item after the input register
   typedef struct packed {
      logic [PIX_W-1:0]   red;
      logic [PIX_W-1:0]   green;
      logic [PIX_W-1:0]   blue;
      logic [PIX_W-1:0]   alpha;
      logic [INDEX_W-1:0] texel_index;
      logic               row_end;
   } s1_item_type;

   // Item after the key test and weighted sum
   typedef struct packed {
      logic [PIX_W-1:0]   red;
      logic [PIX_W-1:0]   green;
      logic [PIX_W-1:0]   blue;
      logic [PIX_W-1:0]   alpha;
      logic [SUM_W-1:0]   lum_sum;
      logic [INDEX_W-1:0] texel_index;
      logic               row_end;
   } s2_item_type;

endpackage

>>> hdl/tcgp_req_if.sv
// Source pixel channel: valid/ready handshake and RGBA8888 payload.
interface tcgp_req_if import tcgp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;
   logic [PIX_W-1:0] alpha;
   logic             first_pixel;

   modport source (output valid, output red, output green, output blue, output alpha,
                   output first_pixel, input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   input first_pixel, output ready);
endinterface

>>> hdl/tcgp_rsp_if.sv
// Texel result channel: valid/ready handshake, packed texel and its index.
interface tcgp_rsp_if import tcgp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [TEXEL_W-1:0] texel;
   logic [INDEX_W-1:0] texel_index;
   logic               row_end;

   modport source (output valid, output texel, output texel_index, output row_end,
                   input ready);
   modport sink   (input valid, input texel, input texel_index, input row_end,
                   output ready);
endinterface

>>> hdl/texel_colorkey_gray_packer.sv
// Top level: RGBA8888 to packed texel with colour key, greyscale and row indexing.
// Each item passes the input, weighted-sum and result registers before its texel
// shows on the result channel; throughput is one item per cycle while the result
// side is not stalled. The three register stages each advance independently,
// so a stall only fills bubbles behind it.
// Reset (synchronous, active high) empties all stages, zeroes column and row base
// and returns registers to their defaults (32-bit format, width and stride of 1).
module texel_colorkey_gray_packer import tcgp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   tcgp_req_if.sink              req_if,
   tcgp_rsp_if.source            rsp_if
);

   // Configuration registers
   logic                 key_enable_ff;
   logic [KEY_W-1:0]     key_color_ff;
   logic                 mono_enable_ff;
   out_format_type       out_format_ff;
   logic [WIDTH_W-1:0]   image_width_ff;
   logic [WIDTH_W-1:0]   row_stride_ff;

   // Row state
   logic [COL_W-1:0]     column_ff,   column_in;
   logic [INDEX_W-1:0]   row_base_ff, row_base_in;

   // Pipeline
   logic                 s1_valid_ff, s2_valid_ff, out_valid_ff;
   s1_item_type          s1_ff, s1_in;
   s2_item_type          s2_ff, s2_in;
   logic [TEXEL_W-1:0]   texel_ff, texel_in;
   logic [INDEX_W-1:0]   index_ff;
   logic                 row_end_ff;

   logic                 s1_ready, s2_ready, out_ready, accept;
   logic [COL_W-1:0]     col_cur, last_col;
   logic [INDEX_W-1:0]   base_cur;
   logic [WIDTH_W-1:0]   width_eff;
   logic                 last;
   logic                 key_hit;
   logic [PROD_W-1:0]    lum_prod;
   logic [PIX_W-1:0]     lum, red_o, green_o, blue_o;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         key_enable_ff  <= 1'b0;
         key_color_ff   <= '0;
         mono_enable_ff <= 1'b0;
         out_format_ff  <= FMT_RGBA8888;
         image_width_ff <= WIDTH_W'(1);
         row_stride_ff  <= WIDTH_W'(1);
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_ENABLE:  key_enable_ff  <= csr_write_data[0];
            CSR_KEY_COLOR:   key_color_ff   <= csr_write_data[KEY_W-1:0];
            CSR_MONO_ENABLE: mono_enable_ff <= csr_write_data[0];
            CSR_OUT_FORMAT:  out_format_ff  <= out_format_type'(csr_write_data[0]);
            CSR_IMAGE_WIDTH: image_width_ff <= csr_write_data[WIDTH_W-1:0];
            CSR_ROW_STRIDE:  row_stride_ff  <= csr_write_data[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage handshakes: each stage takes a new item when empty or draining
   assign out_ready = !out_valid_ff || rsp_if.ready;
   assign s2_ready  = !s2_valid_ff  || out_ready;
   assign s1_ready  = !s1_valid_ff  || s2_ready;
   assign accept    = req_if.valid && s1_ready;
   assign req_if.ready = s1_ready;

   // Column / row indexing at acceptance; width is clamped to 1..MAX_WIDTH
   always_comb begin
      if (image_width_ff == '0)
         width_eff = WIDTH_W'(1);
      else if (image_width_ff > WIDTH_W'(MAX_WIDTH))
         width_eff = WIDTH_W'(MAX_WIDTH);
      else
         width_eff = image_width_ff;
      last_col = COL_W'(width_eff - WIDTH_W'(1));
      col_cur  = req_if.first_pixel ? '0 : column_ff;
      base_cur = req_if.first_pixel ? '0 : row_base_ff;
      last     = col_cur >= last_col;
      if (last) begin
         column_in   = '0;
         row_base_in = base_cur + INDEX_W'(row_stride_ff);
      end else begin
         column_in   = col_cur + COL_W'(1);
         row_base_in = base_cur;
      end
      s1_in.red         = req_if.red;
      s1_in.green       = req_if.green;
      s1_in.blue        = req_if.blue;
      s1_in.alpha       = req_if.alpha;
      s1_in.texel_index = base_cur + INDEX_W'(col_cur);
      s1_in.row_end     = last;
   end

   // Key test on source RGB, then weighted luminance sum in hundredths
   always_comb begin
      key_hit = key_enable_ff &&
                ({s1_ff.blue, s1_ff.green, s1_ff.red} == key_color_ff);
      s2_in.red         = s1_ff.red;
      s2_in.green       = s1_ff.green;
      s2_in.blue        = s1_ff.blue;
      s2_in.alpha       = key_hit ? '0 : s1_ff.alpha;
      s2_in.lum_sum     = SUM_W'(s1_ff.red)   * SUM_W'(LUM_WR)
                        + SUM_W'(s1_ff.green) * SUM_W'(LUM_WG)
                        + SUM_W'(s1_ff.blue)  * SUM_W'(LUM_WB);
      s2_in.texel_index = s1_ff.texel_index;
      s2_in.row_end     = s1_ff.row_end;
   end

   // Divide by 100 through the reciprocal (exact for sums up to 25500), then pack
   always_comb begin
      lum_prod = PROD_W'(s2_ff.lum_sum) * PROD_W'(LUM_RECIP);
      lum      = lum_prod[RECIP_SH +: PIX_W];
      red_o    = mono_enable_ff ? lum : s2_ff.red;
      green_o  = mono_enable_ff ? lum : s2_ff.green;
      blue_o   = mono_enable_ff ? lum : s2_ff.blue;
      case (out_format_ff)
         FMT_RGBA4444: texel_in = {16'h0000, red_o[7:4], green_o[7:4], blue_o[7:4],
                                   s2_ff.alpha[7:4]};
         FMT_RGBA8888: texel_in = {s2_ff.alpha, blue_o, green_o, red_o};
         default:      texel_in = '0;
      endcase
   end

   // Control state: row counters and stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         row_base_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            column_ff   <= column_in;
            row_base_ff <= row_base_in;
         end
         if (s1_ready)  s1_valid_ff  <= req_if.valid;
         if (s2_ready)  s2_valid_ff  <= s1_valid_ff;
         if (out_ready) out_valid_ff <= s2_valid_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (s1_ready) s1_ff <= s1_in;
      if (s2_ready) s2_ff <= s2_in;
      if (out_ready) begin
         texel_ff   <= texel_in;
         index_ff   <= s2_ff.texel_index;
         row_end_ff <= s2_ff.row_end;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.texel       = texel_ff;
   assign rsp_if.texel_index = index_ff;
   assign rsp_if.row_end     = row_end_ff;

endmodule

>>> hdl/tcgp_checker.sv
// Port-level checker for the texel packer, bound to the top level.
module tcgp_checker import tcgp_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  csr_write_enable,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_write_data,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [TEXEL_W-1:0]    texel,
   input logic [INDEX_W-1:0]    texel_index,
   input logic                  row_end
);

   // Shadow copies of format and greyscale enable, plus items in flight
   out_format_type fmt_ff;
   logic           mono_ff;
   logic [1:0]     pending_ff;
   logic [1:0]     pending_in;
   logic           in_acc, out_acc;

   assign in_acc     = req_valid && req_ready;
   assign out_acc    = rsp_valid && rsp_ready;
   assign pending_in = 2'(pending_ff + {1'b0, in_acc} - {1'b0, out_acc});

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff     <= FMT_RGBA8888;
         mono_ff    <= 1'b0;
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_OUT_FORMAT:  fmt_ff  <= out_format_type'(csr_write_data[0]);
               CSR_MONO_ENABLE: mono_ff <= csr_write_data[0];
               default: ;
            endcase
         end
      end
   end

   // A stalled result item holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(texel) &&
      $stable(texel_index) && $stable(row_end))
      else $error("result item changed while stalled");

   // No result item appears without an accepted input item behind it
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result item without a pending input item");

   // Nothing is shown in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // 16-bit format leaves the upper half clear
   a_4444_upper: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fmt_ff == FMT_RGBA4444 |-> texel[31:16] == 16'h0000)
      else $error("upper texel half set in 16-bit format");

   // Greyscale in 32-bit format gives equal red, green and blue bytes
   a_mono_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mono_ff && fmt_ff == FMT_RGBA8888 |->
      texel[7:0] == texel[15:8] && texel[15:8] == texel[23:16])
      else $error("greyscale texel with unequal channels");

endmodule

bind texel_colorkey_gray_packer tcgp_checker u_tcgp_checker (
   .clock            (clock),
   .reset            (reset),
   .csr_write_enable (csr_write_enable),
   .csr_index        (csr_index),
   .csr_write_data   (csr_write_data),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .texel            (rsp_if.texel),
   .texel_index      (rsp_if.texel_index),
   .row_end          (rsp_if.row_end)
);

>>> tb/sv/texel_checker_pkg.sv
// Scoreboard for the texel packer: predicts each packed texel and its index, checks results.
package texel_checker_pkg;
   import tcgp_pkg::*;

   // One expected texel on the result channel
   typedef struct packed {
      logic [TEXEL_W-1:0] texel;
      logic [INDEX_W-1:0] texel_index;
      logic               row_end;
   } texel_result_type;

   class texel_scoreboard;
      // Copies of the configuration registers
      bit                   key_enable;
      bit [KEY_W-1:0]       key_color;
      bit                   mono_enable;
      out_format_type       out_format;
      bit [WIDTH_W-1:0]     image_width;
      bit [WIDTH_W-1:0]     row_stride;
      // Raster position of the next pixel
      bit [COL_W-1:0]       column;
      bit [INDEX_W-1:0]     row_base;
      // Texels still owed by the block, oldest first
      texel_result_type     pending_texels[$];
      int                   error_count;

      function new();
         reset_state();
         error_count = 0;
      endfunction

      function void reset_state();
         key_enable  = 1'b0;
         key_color   = '0;
         mono_enable = 1'b0;
         out_format  = FMT_RGBA8888;
         image_width = WIDTH_W'(1);
         row_stride  = WIDTH_W'(1);
         column      = '0;
         row_base    = '0;
         pending_texels.delete();
      endfunction

      function void write_register(input csr_index_type idx,
                                   input bit [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_KEY_ENABLE:  key_enable  = value[0];
            CSR_KEY_COLOR:   key_color   = value[KEY_W-1:0];
            CSR_MONO_ENABLE: mono_enable = value[0];
            CSR_OUT_FORMAT:  out_format  = out_format_type'(value[0]);
            CSR_IMAGE_WIDTH: image_width = value[WIDTH_W-1:0];
            CSR_ROW_STRIDE:  row_stride  = value[WIDTH_W-1:0];
            default: ;
         endcase
      endfunction

      // Work out the texel for an accepted pixel and queue it
      function void note_pixel(input bit [PIX_W-1:0] red, input bit [PIX_W-1:0] green,
                               input bit [PIX_W-1:0] blue, input bit [PIX_W-1:0] alpha,
                               input bit first_pixel);
         texel_result_type want;
         int               eff_width;
         int               luma;
         // zero width behaves as one, anything past the maximum is clipped
         eff_width = int'(image_width);
         if (eff_width == 0)
            eff_width = 1;
         if (eff_width > MAX_WIDTH)
            eff_width = MAX_WIDTH;
         if (first_pixel) begin
            column   = '0;
            row_base = '0;
         end
         // key test looks at the source colour, ahead of any greyscale
         if (key_enable && {blue, green, red} == key_color)
            alpha = '0;
         // luminance with weights in hundredths, truncated
         if (mono_enable) begin
            luma  = (30 * int'(red) + 59 * int'(green) + 11 * int'(blue)) / 100;
            red   = PIX_W'(luma);
            green = PIX_W'(luma);
            blue  = PIX_W'(luma);
         end
         if (out_format == FMT_RGBA4444)
            want.texel = {16'h0000, red[7:4], green[7:4], blue[7:4], alpha[7:4]};
         else
            want.texel = {alpha, blue, green, red};
         want.texel_index = row_base + INDEX_W'(column);
         want.row_end     = (int'(column) >= eff_width - 1);
         // advance the raster position; stride is added as given
         if (want.row_end) begin
            column   = '0;
            row_base = row_base + INDEX_W'(row_stride);
         end else begin
            column = column + 1'b1;
         end
         pending_texels.push_back(want);
      endfunction

      // Compare a texel taken from the block with the oldest expectation
      function void check_texel(input logic [TEXEL_W-1:0] texel,
                                input logic [INDEX_W-1:0] texel_index,
                                input logic row_end, input realtime now_ns);
         texel_result_type want;
         if (pending_texels.size() == 0) begin
            $display("%0.1f ns: texel with nothing expected, expected none, actual %h/%h/%b",
                     now_ns, texel, texel_index, row_end);
            error_count++;
            return;
         end
         want = pending_texels.pop_front();
         if (texel !== want.texel) begin
            $display("%0.1f ns: texel mismatch, expected %h, actual %h",
                     now_ns, want.texel, texel);
            error_count++;
         end
         if (texel_index !== want.texel_index) begin
            $display("%0.1f ns: texel_index mismatch, expected %h, actual %h",
                     now_ns, want.texel_index, texel_index);
            error_count++;
         end
         if (row_end !== want.row_end) begin
            $display("%0.1f ns: row_end mismatch, expected %b, actual %b",
                     now_ns, want.row_end, row_end);
            error_count++;
         end
      endfunction
   endclass

endpackage

>>> tb/sv/testbench.sv
// Top-level testbench for the texel packer: pixel driver, texel monitor and watchdog.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tcgp_pkg::*;
   import texel_checker_pkg::*;

   localparam int PIPE_LATENCY = 3;
   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 420;
   localparam int STRIDE_ITEMS = 40;
   localparam int HOLD_CYCLES  = 120;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   tcgp_req_if req_ch();
   tcgp_rsp_if rsp_ch();

   texel_scoreboard texels;

   // Sender burst state and the request for a long receiver hold-off
   bit gapless;
   int burst_left;
   bit hold_off_request;

   texel_colorkey_gray_packer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Register write: one cycle with the enable high
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      texels.write_register(idx, value);
   endtask

   // Offer one pixel, with a random gap between bursts, and wait for it to be taken
   task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] a,
                             input logic first_px);
      int gap;
      if (burst_left == 0) begin
         gap = gapless ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_ch.valid       <= 1'b1;
      req_ch.red         <= r;
      req_ch.green       <= g;
      req_ch.blue        <= b;
      req_ch.alpha       <= a;
      req_ch.first_pixel <= first_px;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      texels.note_pixel(r, g, b, a, first_px);
   endtask

   // Stop offering and wait until every texel owed has come out
   task automatic finish_phase();
      req_ch.valid <= 1'b0;
      while (texels.pending_texels.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 1) @(posedge clock);
   endtask

   // Random pixel, often the key colour or all-zero / all-one channels
   task automatic pick_pixel(output logic [PIX_W-1:0] r, output logic [PIX_W-1:0] g,
                             output logic [PIX_W-1:0] b, output logic [PIX_W-1:0] a);
      case ($urandom_range(0, 9))
         0, 1: begin
            {b, g, r} = texels.key_color;
            a = PIX_W'($urandom);
         end
         2: begin
            r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         default: {b, g, r, a} = $urandom;
      endcase
   endtask

   // Random settings for one image; returns how many pixels to send
   task automatic configure_image(output int n_items);
      int w;
      int stride;
      write_csr(CSR_KEY_ENABLE, CSR_DATA_W'($urandom_range(0, 1)));
      write_csr(CSR_KEY_COLOR, CSR_DATA_W'($urandom));
      write_csr(CSR_MONO_ENABLE, CSR_DATA_W'($urandom_range(0, 1)));
      write_csr(CSR_OUT_FORMAT, CSR_DATA_W'($urandom_range(0, 1)));
      case ($urandom_range(0, 11))
         0: w = 1;
         1: w = 2;
         2: w = MAX_WIDTH;
         3: w = $urandom_range(MAX_WIDTH + 1, 8191);
         4: w = 0;
         default: w = $urandom_range(3, 40);
      endcase
      case ($urandom_range(0, 7))
         0: stride = $urandom_range(0, w);
         1: stride = 8191;
         default: stride = w + $urandom_range(0, 8);
      endcase
      if (stride > 8191)
         stride = 8191;
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_csr(CSR_ROW_STRIDE, CSR_DATA_W'(stride));
      // wide rows never finish inside a short image anyway
      n_items = (w >= MAX_WIDTH) ? $urandom_range(20, 40) : $urandom_range(30, 90);
   endtask

   // Stimulus
   initial begin : stimulus
      int         sent;
      int         n_items;
      int         k;
      bit         restart;
      logic [7:0] r, g, b, a;
      texels = new();
      gapless = 1'b0;
      burst_left = 0;
      hold_off_request = 1'b0;
      req_ch.valid       <= 1'b0;
      req_ch.red         <= '0;
      req_ch.green       <= '0;
      req_ch.blue        <= '0;
      req_ch.alpha       <= '0;
      req_ch.first_pixel <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Defaults after reset: 32-bit texels, one pixel per row
      send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b0);
      finish_phase();

      // Key and greyscale together, 4444 packing, zero width and zero stride
      write_csr(CSR_KEY_ENABLE, 24'd1);
      write_csr(CSR_KEY_COLOR, 24'h563412);
      write_csr(CSR_MONO_ENABLE, 24'd1);
      write_csr(CSR_OUT_FORMAT, CSR_DATA_W'(FMT_RGBA4444));
      write_csr(CSR_IMAGE_WIDTH, 24'd0);
      write_csr(CSR_ROW_STRIDE, 24'd0);
      send_pixel(8'h12, 8'h34, 8'h56, 8'h9A, 1'b1);
      send_pixel(8'h12, 8'h34, 8'h57, 8'hFF, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'h00, 8'h00, 8'h00, 8'hF0, 1'b0);
      finish_phase();

      // Width beyond the maximum, white key, full-scale key colour
      write_csr(CSR_KEY_COLOR, 24'hFFFFFF);
      write_csr(CSR_MONO_ENABLE, 24'd0);
      write_csr(CSR_OUT_FORMAT, CSR_DATA_W'(FMT_RGBA8888));
      write_csr(CSR_IMAGE_WIDTH, 24'h001FFF);
      write_csr(CSR_ROW_STRIDE, 24'd4096);
      send_pixel(8'h01, 8'h02, 8'h03, 8'h04, 1'b1);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h80, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFE, 8'h80, 1'b0);
      send_pixel(8'h80, 8'h7F, 8'h01, 8'hFE, 1'b0);
      send_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0);
      send_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0);
      finish_phase();

      // Width lowered while the column is already past the new last column
      write_csr(CSR_IMAGE_WIDTH, 24'd3);
      send_pixel(8'h10, 8'h20, 8'h30, 8'h40, 1'b0);
      send_pixel(8'h11, 8'h21, 8'h31, 8'h41, 1'b0);
      send_pixel(8'h12, 8'h22, 8'h32, 8'h42, 1'b0);
      send_pixel(8'h13, 8'h23, 8'h33, 8'h43, 1'b0);
      finish_phase();

      // Stride below width so rows overlap; key colour seen with keying off
      write_csr(CSR_KEY_ENABLE, 24'd0);
      write_csr(CSR_OUT_FORMAT, CSR_DATA_W'(FMT_RGBA4444));
      write_csr(CSR_IMAGE_WIDTH, 24'd4);
      write_csr(CSR_ROW_STRIDE, 24'd2);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      for (k = 1; k < 8; k++)
         send_pixel(8'(k * 37), 8'(k * 53), 8'(k * 71), 8'(k * 89), 1'b0);
      finish_phase();

      // Random images; the first one runs into a long receiver hold-off
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         configure_image(n_items);
         if (sent == 0) begin
            gapless = 1'b1;
            hold_off_request = 1'b1;
         end else begin
            gapless = ($urandom_range(0, 3) == 0);
         end
         restart = ($urandom_range(0, 9) != 0);
         for (k = 0; k < n_items; k++) begin
            pick_pixel(r, g, b, a);
            send_pixel(r, g, b, a, (k == 0 && restart) || ($urandom_range(0, 49) == 0));
         end
         finish_phase();
         sent += n_items;
      end

      // One pixel per row with the widest stride, so the row base takes large steps
      write_csr(CSR_KEY_ENABLE, 24'd0);
      write_csr(CSR_MONO_ENABLE, 24'd0);
      write_csr(CSR_OUT_FORMAT, CSR_DATA_W'(FMT_RGBA8888));
      write_csr(CSR_IMAGE_WIDTH, 24'd1);
      write_csr(CSR_ROW_STRIDE, 24'd8191);
      gapless = 1'b0;
      for (k = 0; k < STRIDE_ITEMS; k++) begin
         pick_pixel(r, g, b, a);
         send_pixel(r, g, b, a, k == 0);
      end
      finish_phase();

      if (texels.error_count == 0 && texels.pending_texels.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Result side: check accepted texels, then pick ready for the next cycle
   initial begin : receiver
      int mode;
      int mode_left;
      int hold_left;
      int tick;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      tick = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready)
            texels.check_texel(rsp_ch.texel, rsp_ch.texel_index, rsp_ch.row_end, $realtime);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         tick++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ch.ready <= (tick % 3 != 0);
               default: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   // Watchdog: too long with nothing moving on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0.1f ns: no item moved for %0d cycles", $realtime, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
